FILE: sv/rbs_pkg.sv
// ============================================================================
// rbs_pkg - shared types and constants for the 2D ray/box slab test
// Widths, saturation limits, status codes and the flag bundles that travel
// down the pipeline next to the arithmetic.
// ============================================================================
package rbs_pkg;

    localparam int COORD_BITS  = 32;
    localparam int DIFF_W      = COORD_BITS + 1;   // corner minus origin
    localparam int SQ_W        = 2 * COORD_BITS;   // squared length
    localparam int ROOT_W      = COORD_BITS;       // direction length
    localparam int REM_W       = ROOT_W + 3;       // square root remainder
    localparam int SQRT_STAGES = SQ_W / 2;
    localparam int NUM_W       = 2 * COORD_BITS;   // dividend
    localparam int DIV_STAGES  = NUM_W;
    localparam int LANES       = 4;                // lo_x, hi_x, lo_y, hi_y
    localparam int RES_STAGES  = 4;
    localparam int T_W         = 64;
    localparam int SAT_W       = T_W - 1;
    localparam int DIST_W      = 31;

    localparam logic [T_W-1:0]        T_SAT    = {2'b01, {(T_W-2){1'b0}}};
    localparam logic signed [T_W-1:0] T_MIN    = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_MAX    = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] DIST_MAX = T_W'({DIST_W{1'b1}});

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_ZERO_DIR = 2'd2
    } t_status;

    // Per-beat flags; lane order lo_x, hi_x, lo_y, hi_y, axis order x, y.
    typedef struct packed {
        logic [LANES-1:0] neg_diff;
        logic [1:0]       neg_dir;
        logic [1:0]       zero_dir;
        logic [1:0]       miss;
        logic             zero_len;
    } t_flags;

    typedef struct packed {
        logic [DIFF_W-1:0]     mag_lo_x;
        logic [DIFF_W-1:0]     mag_hi_x;
        logic [DIFF_W-1:0]     mag_lo_y;
        logic [DIFF_W-1:0]     mag_hi_y;
        logic [COORD_BITS-1:0] mag_dx;
        logic [COORD_BITS-1:0] mag_dy;
        t_flags                flg;
    } t_pre;

endpackage

FILE: sv/rbs_sqrt_pipe.sv
// ============================================================================
// rbs_sqrt_pipe - pipelined integer square root
// One root bit per stage, digit by digit; side data rides along.
// ============================================================================
module rbs_sqrt_pipe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [rbs_pkg::SQ_W-1:0]    i_rad,
    input  rbs_pkg::t_pre               i_side,
    output logic                        o_valid,
    output logic [rbs_pkg::ROOT_W-1:0]  o_root,
    output rbs_pkg::t_pre               o_side
);
    import rbs_pkg::*;

    logic              r_v    [SQRT_STAGES];
    logic [REM_W-1:0]  r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] r_root [SQRT_STAGES];
    logic [SQ_W-1:0]   r_rad  [SQRT_STAGES];
    t_pre              r_side [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic              v_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   rad_in;
        t_pre              side_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down the next bit pair, try 4r+1
        assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1:SQ_W-2]};
        assign trial  = REM_W'({root_in, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
            if (ge) begin
                r_rem[k]  <= rem_sh - trial;
                r_root[k] <= {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[k]  <= rem_sh;
                r_root[k] <= {root_in[ROOT_W-2:0], 1'b0};
            end
            r_rad[k]  <= {rad_in[SQ_W-3:0], 2'b00};
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_v[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];
    assign o_side  = r_side[SQRT_STAGES-1];

endmodule

FILE: sv/rbs_div_pipe.sv
// ============================================================================
// rbs_div_pipe - four-lane pipelined restoring divider
// One quotient bit per stage; lanes 0/1 share divisor 0, lanes 2/3 divisor 1.
// ============================================================================
module rbs_div_pipe (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [rbs_pkg::NUM_W-1:0]       i_num [rbs_pkg::LANES],
    input  logic [rbs_pkg::COORD_BITS-1:0]  i_den [2],
    output logic                            o_valid,
    output logic [rbs_pkg::NUM_W-1:0]       o_quot [rbs_pkg::LANES]
);
    import rbs_pkg::*;

    logic                  r_v   [DIV_STAGES];
    logic [NUM_W-1:0]      r_num [DIV_STAGES][LANES];
    logic [NUM_W-1:0]      r_quo [DIV_STAGES][LANES];
    logic [COORD_BITS-1:0] r_rem [DIV_STAGES][LANES];
    logic [COORD_BITS-1:0] r_den [DIV_STAGES][2];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic                  v_in;
        logic [NUM_W-1:0]      num_in [LANES];
        logic [NUM_W-1:0]      quo_in [LANES];
        logic [COORD_BITS-1:0] rem_in [LANES];
        logic [COORD_BITS-1:0] den_in [2];
        logic [COORD_BITS:0]   sh     [LANES];
        logic [NUM_W-1:0]      n_quo  [LANES];
        logic [COORD_BITS-1:0] n_rem  [LANES];

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign num_in = i_num;
            assign quo_in = '{default: '0};
            assign rem_in = '{default: '0};
            assign den_in = i_den;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
        end

        always_comb begin
            for (int j = 0; j < LANES; j++) begin
                sh[j] = {rem_in[j], num_in[j][NUM_W-1]};
                if (sh[j] >= {1'b0, den_in[1'(j >> 1)]}) begin
                    n_rem[j] = COORD_BITS'(sh[j] - {1'b0, den_in[1'(j >> 1)]});
                    n_quo[j] = {quo_in[j][NUM_W-2:0], 1'b1};
                end else begin
                    n_rem[j] = sh[j][COORD_BITS-1:0];
                    n_quo[j] = {quo_in[j][NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
            for (int j = 0; j < LANES; j++) begin
                r_num[k][j] <= {num_in[j][NUM_W-2:0], 1'b0};
                r_quo[k][j] <= n_quo[j];
                r_rem[k][j] <= n_rem[j];
            end
            r_den[k] <= den_in;
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quot  = r_quo[DIV_STAGES-1];

endmodule

FILE: sv/rbs_slab_resolve.sv
// ============================================================================
// rbs_slab_resolve - slab parameters to hit/miss decision
// Sign and saturate, order per axis, take latest entry and earliest exit,
// then decide and clamp the distance. Four register stages.
// ============================================================================
module rbs_slab_resolve (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [rbs_pkg::NUM_W-1:0]    i_quot [rbs_pkg::LANES],
    input  rbs_pkg::t_flags              i_flags,
    output logic                         o_strobe,
    output rbs_pkg::t_status             o_status,
    output logic [rbs_pkg::DIST_W-1:0]   o_distance
);
    import rbs_pkg::*;

    logic                  r_v1, r_v2, r_v3;
    t_flags                r_f1, r_f2, r_f3;
    logic signed [T_W-1:0] r_t1 [LANES];
    logic signed [T_W-1:0] r_tin [2];
    logic signed [T_W-1:0] r_tout [2];
    logic signed [T_W-1:0] r_close, r_far;
    logic signed [T_W-1:0] n_t1 [LANES];
    logic signed [T_W-1:0] n_tin [2];
    logic signed [T_W-1:0] n_tout [2];
    logic [SAT_W-1:0]      sat [LANES];
    logic                  miss;

    // stage 1: saturate the magnitude and apply the sign
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            sat[j] = (i_quot[j] > T_SAT) ? T_SAT[SAT_W-1:0] : i_quot[j][SAT_W-1:0];
            if ((i_flags.neg_diff[j] != i_flags.neg_dir[1'(j >> 1)]) && (sat[j] != '0)) begin
                n_t1[j] = -$signed(T_W'(sat[j]));
            end else begin
                n_t1[j] = $signed(T_W'(sat[j]));
            end
        end
    end

    // stage 2: order each slab, open up an axis with no direction
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if (r_f1.zero_dir[a]) begin
                n_tin[a]  = T_MIN;
                n_tout[a] = T_MAX;
            end else if (r_t1[2*a] > r_t1[2*a+1]) begin
                n_tin[a]  = r_t1[2*a+1];
                n_tout[a] = r_t1[2*a];
            end else begin
                n_tin[a]  = r_t1[2*a];
                n_tout[a] = r_t1[2*a+1];
            end
        end
    end

    assign miss = (|r_f3.miss) || (r_far < r_close) || (r_far < 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_v1     <= i_valid;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            o_strobe <= r_v3;
        end
        r_t1   <= n_t1;
        r_f1   <= i_flags;
        r_tin  <= n_tin;
        r_tout <= n_tout;
        r_f2   <= r_f1;
        // stage 3: latest entry, earliest exit
        r_close <= (r_tin[0] > r_tin[1]) ? r_tin[0] : r_tin[1];
        r_far   <= (r_tout[0] < r_tout[1]) ? r_tout[0] : r_tout[1];
        r_f3    <= r_f2;
        // stage 4: decide
        if (r_f3.zero_len) begin
            o_status   <= ST_ZERO_DIR;
            o_distance <= '0;
        end else if (miss) begin
            o_status   <= ST_MISS;
            o_distance <= '0;
        end else begin
            o_status <= ST_HIT;
            if (r_close <= 0) begin
                o_distance <= '0;
            end else if (r_close > DIST_MAX) begin
                o_distance <= DIST_MAX[DIST_W-1:0];
            end else begin
                o_distance <= r_close[DIST_W-1:0];
            end
        end
    end

endmodule

FILE: sv/ray_box_slab_intersect_2d.sv
// ============================================================================
// ray_box_slab_intersect_2d - 2D ray versus axis-aligned box, slab method
// Stages: 3 input/prep stages, 32 root stages, 1 multiply, 64 divide, 4 resolve.
// Throughput: one beat per cycle; busy is low whenever reset is released.
// Reset: synchronous, clears every valid bit; payload registers are not reset.
// ============================================================================
module ray_box_slab_intersect_2d (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [rbs_pkg::COORD_BITS-1:0] i_ray_pos_x,
    input  logic signed [rbs_pkg::COORD_BITS-1:0] i_ray_pos_y,
    input  logic signed [rbs_pkg::COORD_BITS-1:0] i_ray_dir_x,
    input  logic signed [rbs_pkg::COORD_BITS-1:0] i_ray_dir_y,
    input  logic signed [rbs_pkg::COORD_BITS-1:0] i_box_min_x,
    input  logic signed [rbs_pkg::COORD_BITS-1:0] i_box_min_y,
    input  logic signed [rbs_pkg::COORD_BITS-1:0] i_box_max_x,
    input  logic signed [rbs_pkg::COORD_BITS-1:0] i_box_max_y,
    output logic                                  o_strobe,
    output logic [1:0]                            o_status,
    output logic [rbs_pkg::DIST_W-1:0]            o_distance
);
    import rbs_pkg::*;

    // ---------------------------------------------------------------------
    // Stage 0: capture the beat
    // ---------------------------------------------------------------------
    logic                         r_v0;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_dx, r_dy, r_nx, r_ny, r_xx, r_xy;

    // The pipeline never stalls; hold off only while in reset.
    assign busy = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
        if (start) begin
            r_px <= i_ray_pos_x;
            r_py <= i_ray_pos_y;
            r_dx <= i_ray_dir_x;
            r_dy <= i_ray_dir_y;
            r_nx <= i_box_min_x;
            r_ny <= i_box_min_y;
            r_xx <= i_box_max_x;
            r_xy <= i_box_max_y;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: corner differences, magnitudes, squares, early flags
    // ---------------------------------------------------------------------
    logic signed [DIFF_W-1:0] w_dlx, w_dhx, w_dly, w_dhy;
    logic [COORD_BITS-1:0]    w_adx, w_ady;
    t_pre                     n_pre;
    logic                     r_v1;
    logic [SQ_W-1:0]          r_sqx, r_sqy;
    t_pre                     r_pre1;

    assign w_dlx = DIFF_W'(r_nx) - DIFF_W'(r_px);
    assign w_dhx = DIFF_W'(r_xx) - DIFF_W'(r_px);
    assign w_dly = DIFF_W'(r_ny) - DIFF_W'(r_py);
    assign w_dhy = DIFF_W'(r_xy) - DIFF_W'(r_py);
    assign w_adx = r_dx[COORD_BITS-1] ? COORD_BITS'(-r_dx) : COORD_BITS'(r_dx);
    assign w_ady = r_dy[COORD_BITS-1] ? COORD_BITS'(-r_dy) : COORD_BITS'(r_dy);

    always_comb begin
        n_pre.mag_lo_x = w_dlx[DIFF_W-1] ? DIFF_W'(-w_dlx) : DIFF_W'(w_dlx);
        n_pre.mag_hi_x = w_dhx[DIFF_W-1] ? DIFF_W'(-w_dhx) : DIFF_W'(w_dhx);
        n_pre.mag_lo_y = w_dly[DIFF_W-1] ? DIFF_W'(-w_dly) : DIFF_W'(w_dly);
        n_pre.mag_hi_y = w_dhy[DIFF_W-1] ? DIFF_W'(-w_dhy) : DIFF_W'(w_dhy);
        n_pre.mag_dx   = w_adx;
        n_pre.mag_dy   = w_ady;
        n_pre.flg.neg_diff = {w_dhy[DIFF_W-1], w_dly[DIFF_W-1],
                              w_dhx[DIFF_W-1], w_dlx[DIFF_W-1]};
        n_pre.flg.neg_dir  = {r_dy[COORD_BITS-1], r_dx[COORD_BITS-1]};
        n_pre.flg.zero_dir = {(r_dy == 0), (r_dx == 0)};
        // a flat axis misses at once when the origin is outside that slab
        n_pre.flg.miss[0]  = (r_dx == 0) && ((r_px < r_nx) || (r_xx < r_px));
        n_pre.flg.miss[1]  = (r_dy == 0) && ((r_py < r_ny) || (r_xy < r_py));
        n_pre.flg.zero_len = (r_dx == 0) && (r_dy == 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
        r_sqx  <= SQ_W'(w_adx) * SQ_W'(w_adx);
        r_sqy  <= SQ_W'(w_ady) * SQ_W'(w_ady);
        r_pre1 <= n_pre;
    end

    // ---------------------------------------------------------------------
    // Stage 2: squared length (at most 2^63, no carry out)
    // ---------------------------------------------------------------------
    logic            r_v2;
    logic [SQ_W-1:0] r_rad;
    t_pre            r_pre2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_rad  <= r_sqx + r_sqy;
        r_pre2 <= r_pre1;
    end

    // ---------------------------------------------------------------------
    // Direction length: floor of the square root
    // ---------------------------------------------------------------------
    logic              w_sv;
    logic [ROOT_W-1:0] w_root;
    t_pre              w_spre;

    rbs_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_rad   (r_rad),
        .i_side  (r_pre2),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_side  (w_spre)
    );

    // ---------------------------------------------------------------------
    // Multiply stage: |corner - origin| * length, fits in 64 bits
    // ---------------------------------------------------------------------
    logic                  r_mv;
    logic [NUM_W-1:0]      r_prod [LANES];
    logic [COORD_BITS-1:0] r_mden [2];
    t_flags                r_mflg;
    logic [NUM_W:0]        w_full [LANES];

    assign w_full[0] = (NUM_W + 1)'(w_spre.mag_lo_x) * (NUM_W + 1)'(w_root);
    assign w_full[1] = (NUM_W + 1)'(w_spre.mag_hi_x) * (NUM_W + 1)'(w_root);
    assign w_full[2] = (NUM_W + 1)'(w_spre.mag_lo_y) * (NUM_W + 1)'(w_root);
    assign w_full[3] = (NUM_W + 1)'(w_spre.mag_hi_y) * (NUM_W + 1)'(w_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= w_sv;
        end
        for (int j = 0; j < LANES; j++) begin
            r_prod[j] <= w_full[j][NUM_W-1:0];
        end
        r_mden[0] <= w_spre.mag_dx;
        r_mden[1] <= w_spre.mag_dy;
        r_mflg    <= w_spre.flg;
    end

    // ---------------------------------------------------------------------
    // Divide by |direction| per axis; flags advance beside the divider
    // ---------------------------------------------------------------------
    logic             w_dv;
    logic [NUM_W-1:0] w_quot [LANES];
    t_flags           r_fdly [DIV_STAGES];

    rbs_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_mv),
        .i_num   (r_prod),
        .i_den   (r_mden),
        .o_valid (w_dv),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        r_fdly[0] <= r_mflg;
        for (int i = 1; i < DIV_STAGES; i++) begin
            r_fdly[i] <= r_fdly[i-1];
        end
    end

    // ---------------------------------------------------------------------
    // Resolve the slabs and drive the result beat
    // ---------------------------------------------------------------------
    t_status w_status;

    rbs_slab_resolve u_res (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_dv),
        .i_quot     (w_quot),
        .i_flags    (r_fdly[DIV_STAGES-1]),
        .o_strobe   (o_strobe),
        .o_status   (w_status),
        .o_distance (o_distance)
    );

    assign o_status = w_status;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_dist_zero_unless_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (w_status != ST_HIT) |-> o_distance == '0)
        else $error("distance nonzero on a non-hit beat");

    a_strobe_follows_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_dv, RES_STAGES))
        else $error("result beat without a divider beat");

    a_div_follows_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv |-> $past(r_mv, DIV_STAGES))
        else $error("divider valid out of step with multiply stage");

    a_zero_dir_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (w_status == ST_ZERO_DIR) |->
            $past(r_fdly[DIV_STAGES-1].zero_len, RES_STAGES))
        else $error("zero-length status without its flag");

endmodule
